@@ sv/vtm_pkg.sv @@
// package for the video timing multiplier: item and config types, constants
// used by vtm_datapath and video_timing_multiplier, no dependencies
`timescale 1ns / 1ps

package vtm_pkg;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 88;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // rounding of (x*5 + 50) / 100: (x + 10) / 20 = ((x + 10) >> 2) / 5
    localparam logic [4:0] ROUND_BIAS = 5'd10;
    localparam logic [7:0] DIV5_MUL = 8'd205;
    localparam int DIV5_SHIFT = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_H_SYNC_MAX   = 3'd0,
        CFG_H_BPORCH_MAX = 3'd1,
        CFG_H_ACTIVE_MAX = 3'd2,
        CFG_V_SYNC_MAX   = 3'd3,
        CFG_V_BPORCH_MAX = 3'd4,
        CFG_V_ACTIVE_MAX = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  hs_lim;
        logic [8:0]  hbp_lim;
        logic [11:0] ha_lim;
        logic [2:0]  vs_lim;
        logic [7:0]  vbp_lim;
        logic [10:0] va_lim;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  in_h_sync;
        logic [8:0]  in_h_bporch;
        logic [11:0] in_h_active;
        logic [11:0] in_h_total;
        logic [7:0]  in_h_total_adj;
        logic [2:0]  in_v_sync;
        logic [7:0]  in_v_bporch;
        logic [10:0] in_v_active;
        logic [10:0] in_v_total;
        logic        in_interlaced;
        logic [3:0]  h_factor;
        logic [3:0]  v_factor;
    } t_timing_in;

    typedef struct packed {
        logic [7:0]  out_h_sync;
        logic [8:0]  out_h_bporch;
        logic [11:0] out_h_active;
        logic [15:0] out_h_total;
        logic [2:0]  out_v_sync;
        logic [7:0]  out_v_bporch;
        logic [10:0] out_v_active;
        logic [15:0] out_v_total;
        logic        out_interlaced;
    } t_timing_out;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_pipe_ctrl;

endpackage

@@ sv/vtm_datapath.sv @@
// three-stage datapath of the video timing multiplier: products, clamps, totals
// depends on vtm_pkg
`timescale 1ns / 1ps

module vtm_datapath (
    input  logic                 i_clk,
    input  vtm_pkg::t_pipe_ctrl  i_ctrl,
    input  vtm_pkg::t_cfg        i_cfg,
    input  vtm_pkg::t_timing_in  i_item,
    output vtm_pkg::t_timing_out o_item
);

    // stage 1: products
    logic [11:0] r_hs_p;
    logic [12:0] r_hbp_p;
    logic [15:0] r_ha_p;
    logic [15:0] r_ht_p;
    logic [11:0] r_hadj_p;
    logic [6:0]  r_vs_p;
    logic [11:0] r_vbp_p;
    logic [14:0] r_va_p;
    logic [14:0] r_vt_p;
    logic        r_il1;

    logic [3:0] n_vm_eff;
    logic       n_il;

    always_comb begin
        if (i_item.in_interlaced && !i_item.v_factor[0]) begin
            n_vm_eff = {1'b0, i_item.v_factor[3:1]};
            n_il = 1'b0;
        end else begin
            n_vm_eff = i_item.v_factor;
            n_il = i_item.in_interlaced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_hs_p   <= 12'(i_item.in_h_sync) * 12'(i_item.h_factor);
            r_hbp_p  <= 13'(i_item.in_h_bporch) * 13'(i_item.h_factor);
            r_ha_p   <= 16'(i_item.in_h_active) * 16'(i_item.h_factor);
            r_ht_p   <= 16'(i_item.in_h_total) * 16'(i_item.h_factor);
            r_hadj_p <= 12'(i_item.in_h_total_adj) * 12'(i_item.h_factor);
            r_vs_p   <= 7'(i_item.in_v_sync) * 7'(i_item.v_factor);
            r_vbp_p  <= 12'(i_item.in_v_bporch) * 12'(i_item.v_factor);
            r_va_p   <= 15'(i_item.in_v_active) * 15'(i_item.v_factor);
            r_vt_p   <= 15'(i_item.in_v_total) * 15'(n_vm_eff);
            r_il1    <= n_il;
        end
    end

    // stage 2: sync and active clamps, overflow into back porch, rounding multiply
    logic [7:0]  n_hs_o;
    logic [11:0] n_hs_x;
    logic [2:0]  n_vs_o;
    logic [6:0]  n_vs_x;
    logic [11:0] n_adj_b;

    logic [7:0]  r_hs_o;
    logic [13:0] r_hbp_s;
    logic [11:0] r_ha_o;
    logic [15:0] r_ht2;
    logic [17:0] r_adj_m;
    logic [2:0]  r_vs_o;
    logic [12:0] r_vbp_s;
    logic [10:0] r_va_o;
    logic [14:0] r_vt2;
    logic        r_il2;

    always_comb begin
        n_hs_o = (r_hs_p > 12'(i_cfg.hs_lim)) ? i_cfg.hs_lim : r_hs_p[7:0];
        n_hs_x = r_hs_p - 12'(n_hs_o);
        n_vs_o = (r_vs_p > 7'(i_cfg.vs_lim)) ? i_cfg.vs_lim : r_vs_p[2:0];
        n_vs_x = r_vs_p - 7'(n_vs_o);
        n_adj_b = r_hadj_p + 12'(vtm_pkg::ROUND_BIAS);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_hs_o  <= n_hs_o;
            r_hbp_s <= 14'(r_hbp_p) + 14'(n_hs_x);
            r_ha_o  <= (r_ha_p > 16'(i_cfg.ha_lim)) ? i_cfg.ha_lim : r_ha_p[11:0];
            r_ht2   <= r_ht_p;
            r_adj_m <= 18'(n_adj_b[11:2]) * 18'(vtm_pkg::DIV5_MUL);
            r_vs_o  <= n_vs_o;
            r_vbp_s <= 13'(r_vbp_p) + 13'(n_vs_x);
            r_va_o  <= (r_va_p > 15'(i_cfg.va_lim)) ? i_cfg.va_lim : r_va_p[10:0];
            r_vt2   <= r_vt_p;
            r_il2   <= r_il1;
        end
    end

    // stage 3: back porch clamps and horizontal total, output register
    vtm_pkg::t_timing_out r_out;
    logic [7:0] n_round;

    assign n_round = r_adj_m[vtm_pkg::DIV5_SHIFT +: 8];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_out.out_h_sync     <= r_hs_o;
            r_out.out_h_bporch   <= (r_hbp_s > 14'(i_cfg.hbp_lim)) ? i_cfg.hbp_lim
                                                                  : r_hbp_s[8:0];
            r_out.out_h_active   <= r_ha_o;
            r_out.out_h_total    <= r_ht2 + 16'(n_round);
            r_out.out_v_sync     <= r_vs_o;
            r_out.out_v_bporch   <= (r_vbp_s > 13'(i_cfg.vbp_lim)) ? i_cfg.vbp_lim
                                                                  : r_vbp_s[7:0];
            r_out.out_v_active   <= r_va_o;
            r_out.out_v_total    <= 16'(r_vt2);
            r_out.out_interlaced <= r_il2;
        end
    end

    assign o_item = r_out;

endmodule

@@ sv/video_timing_multiplier.sv @@
// top level of the video timing multiplier: stream ports, config registers,
// pipeline handshake; depends on vtm_pkg and vtm_datapath
//
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------------
// s        | in        | i_s_tvalid/o_s_tready  | i_s_tdata, i_s_tuser (timing set)
// m        | out       | o_m_tvalid/i_m_tready  | o_m_tdata, o_m_tuser (scaled set)
// cfg      | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// one item per cycle while not stalled, through three register stages (multiply, clamp, total/output)
// an accepted item is registered in the multiply, then clamp, then total/output stage, where its result is valid
// each stage holds its item while the stage after it is full and stalled
// synchronous active-low reset clears stage valids and sets all maxima to all ones
// config writes are always accepted; indexes above five are ignored
`timescale 1ns / 1ps

module video_timing_multiplier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // hsync, hbporch, hactive, htotal, htotal adj, vsync, vbporch,
    // vactive, vtotal, hfactor, vfactor, zero pad
    input  logic [vtm_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // in_interlaced
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // hsync, hbporch, hactive, htotal, vsync, vbporch, vactive,
    // vtotal, zero pad
    output logic [vtm_pkg::M_TDATA_W-1:0]    o_m_tdata,
    // out_interlaced
    output logic                             o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vtm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vtm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    vtm_pkg::t_cfg        r_cfg;
    vtm_pkg::t_pipe_ctrl  n_ctrl;
    vtm_pkg::t_timing_in  n_item;
    vtm_pkg::t_timing_out n_res;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hs_lim  <= '1;
            r_cfg.hbp_lim <= '1;
            r_cfg.ha_lim  <= '1;
            r_cfg.vs_lim  <= '1;
            r_cfg.vbp_lim <= '1;
            r_cfg.va_lim  <= '1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vtm_pkg::CFG_H_SYNC_MAX:   r_cfg.hs_lim  <= i_cfg_data[7:0];
                vtm_pkg::CFG_H_BPORCH_MAX: r_cfg.hbp_lim <= i_cfg_data[8:0];
                vtm_pkg::CFG_H_ACTIVE_MAX: r_cfg.ha_lim  <= i_cfg_data[11:0];
                vtm_pkg::CFG_V_SYNC_MAX:   r_cfg.vs_lim  <= i_cfg_data[2:0];
                vtm_pkg::CFG_V_BPORCH_MAX: r_cfg.vbp_lim <= i_cfg_data[7:0];
                vtm_pkg::CFG_V_ACTIVE_MAX: r_cfg.va_lim  <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // stage enables: a stage loads when it is empty or its item moves on
    always_comb begin
        n_ctrl.en3 = !r_v3 || i_m_tready;
        n_ctrl.en2 = !r_v2 || n_ctrl.en3;
        n_ctrl.en1 = !r_v1 || n_ctrl.en2;
    end

    assign o_s_tready = n_ctrl.en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (n_ctrl.en1) begin
                r_v1 <= i_s_tvalid;
            end
            if (n_ctrl.en2) begin
                r_v2 <= r_v1;
            end
            if (n_ctrl.en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_comb begin
        n_item.in_h_sync      = i_s_tdata[7:0];
        n_item.in_h_bporch    = i_s_tdata[16:8];
        n_item.in_h_active    = i_s_tdata[28:17];
        n_item.in_h_total     = i_s_tdata[40:29];
        n_item.in_h_total_adj = i_s_tdata[48:41];
        n_item.in_v_sync      = i_s_tdata[51:49];
        n_item.in_v_bporch    = i_s_tdata[59:52];
        n_item.in_v_active    = i_s_tdata[70:60];
        n_item.in_v_total     = i_s_tdata[81:71];
        n_item.h_factor       = i_s_tdata[85:82];
        n_item.v_factor       = i_s_tdata[89:86];
        n_item.in_interlaced  = i_s_tuser;
    end

    vtm_datapath u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (n_ctrl),
        .i_cfg  (r_cfg),
        .i_item (n_item),
        .o_item (n_res)
    );

    assign o_m_tvalid = r_v3;
    assign o_m_tuser  = n_res.out_interlaced;
    assign o_m_tdata  = {5'd0,
                         n_res.out_v_total,
                         n_res.out_v_active,
                         n_res.out_v_bporch,
                         n_res.out_v_sync,
                         n_res.out_h_total,
                         n_res.out_h_active,
                         n_res.out_h_bporch,
                         n_res.out_h_sync};

endmodule

@@ tb/tb.sv @@
// self-checking bench for video_timing_multiplier: scales timing sets through the
// stream ports and compares each scaled set with a written-out expectation or with
// a behavioral model kept here; depends on vtm_pkg and video_timing_multiplier
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_ITEMS = 205;
    localparam int MAX_REPORTS = 40;
    localparam logic [vtm_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [vtm_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
    // register tops, index 0 in the low bits
    localparam logic [71:0] REG_TOPS = {12'd2047, 12'd255, 12'd7, 12'd4095, 12'd511, 12'd255};
    localparam vtm_pkg::t_timing_out NO_VALUE = '0;

    typedef struct packed {
        logic                 given;
        vtm_pkg::t_timing_out value;
    } t_item_note;

    typedef struct packed {
        vtm_pkg::t_timing_in  stim;
        logic                 given;
        vtm_pkg::t_timing_out value;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [vtm_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic i_s_tuser = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [vtm_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic o_m_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [vtm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [vtm_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    vtm_pkg::t_cfg limits = '1;
    vtm_pkg::t_timing_out scaled_due [$];
    t_item_note notes [$];
    t_dir_row dir_rows [$];
    int n_sent = 0;
    int n_checked = 0;
    int errors = 0;
    int quiet = 0;
    int hold_req = 0;
    bit idle_on = 1'b0;

    video_timing_multiplier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp(int unsigned v, int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic vtm_pkg::t_timing_out scale_timing(vtm_pkg::t_timing_in t,
                                                          vtm_pkg::t_cfg lim);
        vtm_pkg::t_timing_out r;
        int unsigned hm, vm, prod, sync_o, vmul;
        hm = 32'(t.h_factor);
        vm = 32'(t.v_factor);

        prod = 32'(t.in_h_sync) * hm;
        sync_o = clamp(prod, 32'(lim.hs_lim));
        r.out_h_sync = 8'(sync_o);
        r.out_h_bporch = 9'(clamp(32'(t.in_h_bporch) * hm + (prod - sync_o),
                                  32'(lim.hbp_lim)));
        r.out_h_active = 12'(clamp(32'(t.in_h_active) * hm, 32'(lim.ha_lim)));
        // adjustment is in 0.05 pixel steps, rounded to nearest
        r.out_h_total = 16'(hm * 32'(t.in_h_total)
                            + (hm * 32'(t.in_h_total_adj) * 5 + 50) / 100);

        prod = 32'(t.in_v_sync) * vm;
        sync_o = clamp(prod, 32'(lim.vs_lim));
        r.out_v_sync = 3'(sync_o);
        r.out_v_bporch = 8'(clamp(32'(t.in_v_bporch) * vm + (prod - sync_o),
                                  32'(lim.vbp_lim)));
        r.out_v_active = 11'(clamp(32'(t.in_v_active) * vm, 32'(lim.va_lim)));
        // interlaced with even factor turns progressive, each field spans half
        vmul = (t.in_interlaced && !vm[0]) ? (vm >> 1) : vm;
        r.out_v_total = 16'(32'(t.in_v_total) * vmul);
        r.out_interlaced = t.in_interlaced & vm[0];
        return r;
    endfunction

    function automatic vtm_pkg::t_timing_in mk_in(int unsigned hs, hbp, ha, ht, adj, vs, vbp,
                                                  va, vt, il, hm, vm);
        vtm_pkg::t_timing_in t;
        t.in_h_sync = 8'(hs);
        t.in_h_bporch = 9'(hbp);
        t.in_h_active = 12'(ha);
        t.in_h_total = 12'(ht);
        t.in_h_total_adj = 8'(adj);
        t.in_v_sync = 3'(vs);
        t.in_v_bporch = 8'(vbp);
        t.in_v_active = 11'(va);
        t.in_v_total = 11'(vt);
        t.in_interlaced = 1'(il);
        t.h_factor = 4'(hm);
        t.v_factor = 4'(vm);
        return t;
    endfunction

    function automatic vtm_pkg::t_timing_out mk_out(int unsigned hs, hbp, ha, ht, vs, vbp,
                                                    va, vt, il);
        vtm_pkg::t_timing_out r;
        r.out_h_sync = 8'(hs);
        r.out_h_bporch = 9'(hbp);
        r.out_h_active = 12'(ha);
        r.out_h_total = 16'(ht);
        r.out_v_sync = 3'(vs);
        r.out_v_bporch = 8'(vbp);
        r.out_v_active = 11'(va);
        r.out_v_total = 16'(vt);
        r.out_interlaced = 1'(il);
        return r;
    endfunction

    function automatic int unsigned pick_field(int unsigned top);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    function automatic vtm_pkg::t_timing_in rand_timing();
        return mk_in(pick_field(255), pick_field(511), pick_field(4095), pick_field(4095),
                     pick_field(255), pick_field(7), pick_field(255), pick_field(2047),
                     pick_field(2047), $urandom_range(0, 1), pick_field(15), pick_field(15));
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [71:0] limit_set(int p);
        logic [71:0] v;
        int unsigned top;
        for (int k = 0; k < 6; k++) begin
            top = 32'(REG_TOPS[k*12 +: 12]);
            case (p)
                0: v[k*12 +: 12] = 12'hFFF;
                2, 6: v[k*12 +: 12] = 12'($urandom_range(0, top / 4));
                4: begin
                    case ($urandom_range(0, 2))
                        0: v[k*12 +: 12] = '0;
                        1: v[k*12 +: 12] = 12'(top);
                        default: v[k*12 +: 12] = 12'($urandom_range(0, top));
                    endcase
                end
                7: v[k*12 +: 12] = 12'(top);
                default: v[k*12 +: 12] = 12'($urandom_range(0, 12'hFFF));
            endcase
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("result %0d: %s is %0d, expected %0d", n_checked, what, got, want);
    endtask

    task automatic check_result(logic [vtm_pkg::M_TDATA_W-1:0] d, logic u);
        vtm_pkg::t_timing_out w;
        n_checked++;
        if (scaled_due.size() == 0) begin
            report_mismatch("result with no item pending", 1, 0);
            return;
        end
        w = scaled_due.pop_front();
        if (d[7:0] !== w.out_h_sync)
            report_mismatch("hsync", 32'(d[7:0]), 32'(w.out_h_sync));
        if (d[16:8] !== w.out_h_bporch)
            report_mismatch("hbporch", 32'(d[16:8]), 32'(w.out_h_bporch));
        if (d[28:17] !== w.out_h_active)
            report_mismatch("hactive", 32'(d[28:17]), 32'(w.out_h_active));
        if (d[44:29] !== w.out_h_total)
            report_mismatch("htotal", 32'(d[44:29]), 32'(w.out_h_total));
        if (d[47:45] !== w.out_v_sync)
            report_mismatch("vsync", 32'(d[47:45]), 32'(w.out_v_sync));
        if (d[55:48] !== w.out_v_bporch)
            report_mismatch("vbporch", 32'(d[55:48]), 32'(w.out_v_bporch));
        if (d[66:56] !== w.out_v_active)
            report_mismatch("vactive", 32'(d[66:56]), 32'(w.out_v_active));
        if (d[82:67] !== w.out_v_total)
            report_mismatch("vtotal", 32'(d[82:67]), 32'(w.out_v_total));
        if (u !== w.out_interlaced)
            report_mismatch("interlaced", 32'(u), 32'(w.out_interlaced));
    endtask

    // called at a rising edge, returns at the edge that accepts the item
    task automatic push_timing(vtm_pkg::t_timing_in x, logic given,
                               vtm_pkg::t_timing_out value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        notes.push_back({given, value});
        i_s_tvalid <= 1'b1;
        i_s_tuser <= x.in_interlaced;
        i_s_tdata <= {6'd0, x.v_factor, x.h_factor, x.in_v_total, x.in_v_active,
                      x.in_v_bporch, x.in_v_sync, x.in_h_total_adj, x.in_h_total,
                      x.in_h_active, x.in_h_bporch, x.in_h_sync};
        do @(posedge i_clk); while (!o_s_tready);
        n_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_checked < n_sent);
    endtask

    task automatic program_limits(logic [71:0] vals, bit poke_spare);
        for (int k = int'(vtm_pkg::CFG_H_SYNC_MAX); k <= int'(vtm_pkg::CFG_V_ACTIVE_MAX);
             k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= vtm_pkg::t_cfg_idx'(k);
            i_cfg_data <= vals[k*12 +: 12];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        if (poke_spare) begin
            i_cfg_index <= IDX_SPARE_LO;
            i_cfg_data <= 12'($urandom_range(0, 12'hFFF));
            do @(posedge i_clk); while (!o_cfg_ready);
            i_cfg_index <= IDX_SPARE_HI;
            i_cfg_data <= 12'($urandom_range(0, 12'hFFF));
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end else if (stall_left == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        vtm_pkg::t_timing_in seen;
        t_item_note note;
        logic moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            limits = '1;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    vtm_pkg::CFG_H_SYNC_MAX:   limits.hs_lim = i_cfg_data[7:0];
                    vtm_pkg::CFG_H_BPORCH_MAX: limits.hbp_lim = i_cfg_data[8:0];
                    vtm_pkg::CFG_H_ACTIVE_MAX: limits.ha_lim = i_cfg_data[11:0];
                    vtm_pkg::CFG_V_SYNC_MAX:   limits.vs_lim = i_cfg_data[2:0];
                    vtm_pkg::CFG_V_BPORCH_MAX: limits.vbp_lim = i_cfg_data[7:0];
                    vtm_pkg::CFG_V_ACTIVE_MAX: limits.va_lim = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                moved = 1'b1;
                seen.in_h_sync = i_s_tdata[7:0];
                seen.in_h_bporch = i_s_tdata[16:8];
                seen.in_h_active = i_s_tdata[28:17];
                seen.in_h_total = i_s_tdata[40:29];
                seen.in_h_total_adj = i_s_tdata[48:41];
                seen.in_v_sync = i_s_tdata[51:49];
                seen.in_v_bporch = i_s_tdata[59:52];
                seen.in_v_active = i_s_tdata[70:60];
                seen.in_v_total = i_s_tdata[81:71];
                seen.in_interlaced = i_s_tuser;
                seen.h_factor = i_s_tdata[85:82];
                seen.v_factor = i_s_tdata[89:86];
                note = (notes.size() != 0) ? notes.pop_front() : {1'b0, NO_VALUE};
                scaled_due.push_back(note.given ? note.value : scale_timing(seen, limits));
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                check_result(o_m_tdata, o_m_tuser);
            end
        end
        quiet = moved ? 0 : quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin : stimulus
        t_dir_row row;

        // extremes, identity and rounding points, expectation written out
        dir_rows.push_back({mk_in(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                            mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back({mk_in(10, 20, 640, 800, 0, 2, 33, 480, 525, 0, 1, 1), 1'b1,
                            mk_out(10, 20, 640, 800, 2, 33, 480, 525, 0)});
        dir_rows.push_back({mk_in(255, 511, 4095, 4095, 255, 7, 255, 2047, 2047, 1, 15, 15),
                            1'b1, mk_out(255, 511, 4095, 61616, 7, 255, 2047, 30705, 1)});
        dir_rows.push_back({mk_in(255, 511, 4095, 4095, 255, 7, 255, 2047, 2047, 1, 0, 0),
                            1'b1, mk_out(0, 0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back({mk_in(255, 511, 4095, 4095, 255, 7, 255, 2047, 2047, 0, 1, 1),
                            1'b1, mk_out(255, 511, 4095, 4108, 7, 255, 2047, 2047, 0)});
        dir_rows.push_back({mk_in(0, 0, 0, 100, 9, 0, 0, 0, 0, 0, 1, 1), 1'b1,
                            mk_out(0, 0, 0, 100, 0, 0, 0, 0, 0)});
        dir_rows.push_back({mk_in(0, 0, 0, 100, 10, 0, 0, 0, 0, 0, 1, 1), 1'b1,
                            mk_out(0, 0, 0, 101, 0, 0, 0, 0, 0)});
        // interlace handling, sync carry and bit patterns
        dir_rows.push_back({mk_in(44, 148, 1920, 2200, 0, 5, 15, 540, 1125, 1, 1, 2), 1'b0,
                            NO_VALUE});
        dir_rows.push_back({mk_in(40, 88, 800, 1056, 0, 4, 23, 600, 625, 1, 3, 3), 1'b0,
                            NO_VALUE});
        dir_rows.push_back({mk_in(96, 48, 640, 800, 30, 2, 33, 480, 525, 0, 2, 4), 1'b0,
                            NO_VALUE});
        dir_rows.push_back({mk_in(200, 10, 1000, 1100, 255, 6, 250, 2000, 2047, 1, 2, 14),
                            1'b0, NO_VALUE});
        dir_rows.push_back({mk_in('hAA, 'h0AA, 'hAAA, 'hAAA, 'hAA, 'h2, 'hAA, 'h2AA, 'h2AA,
                                  0, 'hA, 'hA), 1'b0, NO_VALUE});
        dir_rows.push_back({mk_in('h55, 'h155, 'h555, 'h555, 'h55, 'h5, 'h55, 'h555, 'h555,
                                  1, 'h5, 'h5), 1'b0, NO_VALUE});
        dir_rows.push_back({mk_in(255, 0, 4095, 4095, 255, 7, 0, 2047, 2047, 1, 15, 8),
                            1'b0, NO_VALUE});
        dir_rows.push_back({mk_in(1, 511, 1, 1, 1, 1, 255, 1, 1, 0, 15, 0), 1'b0, NO_VALUE});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_on = 1'b0;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            push_timing(row.stim, row.given, row.value);
        end
        drain();

        // all limits at zero: whole sync spills into porch, porch clamps to zero
        program_limits('0, 1'b1);
        idle_on = 1'b1;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (!row.given) push_timing(row.stim, 1'b0, NO_VALUE);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_limits(limit_set(p), p % 4 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
                if (p == 3 && i == 60) begin
                    // output held off while items keep coming, pipeline backs up
                    idle_on = 1'b0;
                    hold_req = HOLD_CYCLES;
                end
                if ($urandom_range(0, 149) == 0) drain();
                push_timing(rand_timing(), 1'b0, NO_VALUE);
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scaled_due.size() != 0)
            report_mismatch("items left without result", scaled_due.size(), 0);

        $display("run covered %0d timing sets, %0d results, reset, zero and %0d limit sets",
                 n_sent, n_checked, NUM_PHASES);
        $display("including a %0d cycle output hold-off and full drains between phases",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
